// ===== rtl/spl_pkg.sv =====
// Package for the stereo peak limiter: widths, level constants, register
// indexes, datapath operation codes and controller/datapath link structs.
// No dependencies.
`timescale 1ns / 1ps
package spl_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int FRAC_W     = SAMPLE_W - 1;
  localparam int WIDE_W     = SAMPLE_W + 3;
  localparam int ENV_W      = SAMPLE_W + 1;
  localparam int GAIN_W     = 16;
  localparam int COEF_W     = 24;
  localparam int SLOPE_W    = 17;
  localparam int COUNT_W    = 32;
  localparam int CHANNELS   = 2;
  localparam int CH_W       = 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_A_W    = 27;
  localparam int MUL_B_W    = 25;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int REM_W      = 51;
  localparam int DIV_STEPS  = 25;
  localparam int DIVCNT_W   = 5;

  localparam logic [SAMPLE_W-1:0] UNITY     = 24'h800000;
  localparam logic [SAMPLE_W-1:0] UNITY_M1  = 24'h7FFFFF;
  localparam logic [WIDE_W-1:0]   KNEE      = 27'd6710886;
  localparam logic [WIDE_W-1:0]   WIDE_MAX  = 27'h7FFFFFF;
  localparam logic [ENV_W-1:0]    ENV_MAX   = 25'h1FFFFFF;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = 32'hFFFFFFFF;

  localparam logic [GAIN_W-1:0]  RST_INPUT_GAIN = 16'd4096;
  localparam logic [COEF_W-1:0]  RST_RELEASE    = 24'd16773721;
  localparam logic [SLOPE_W-1:0] RST_SLOPE      = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_GAIN = 3'd0,
    CFG_THRESHOLD  = 3'd1,
    CFG_CEILING    = 3'd2,
    CFG_RELEASE    = 3'd3,
    CFG_SC_ON      = 3'd4,
    CFG_SC_SLOPE   = 3'd5,
    CFG_METERS_ON  = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL_IN, OP_SAVE_IN, OP_DIV_START, OP_DIV_STEP,
    OP_REL_M1, OP_REL_M2, OP_REL_END, OP_SC_MUL, OP_SC_SAVE, OP_G_MUL,
    OP_G_SAVE, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic div_go;
  } stat_t;

endpackage

// ===== rtl/spl_ctrl.sv =====
// Controller of the stereo peak limiter: sequences one frame through the
// datapath and owns the input ready and output valid. Depends on spl_pkg.
`timescale 1ns / 1ps
module spl_ctrl import spl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_MULIN    = 13'b0000000000010,
    ST_SAVEIN   = 13'b0000000000100,
    ST_DIVSTART = 13'b0000000001000,
    ST_DIVSTEP  = 13'b0000000010000,
    ST_RELM1    = 13'b0000000100000,
    ST_RELM2    = 13'b0000001000000,
    ST_RELEND   = 13'b0000010000000,
    ST_SCMUL    = 13'b0000100000000,
    ST_SCSAVE   = 13'b0001000000000,
    ST_GMUL     = 13'b0010000000000,
    ST_GSAVE    = 13'b0100000000000,
    ST_FINISH   = 13'b1000000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [DIVCNT_W-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                ch_last, slot_free;

  assign ch_last   = (ch_r == CH_W'(CHANNELS - 1));
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.ch        = ch_r;
    cmd.last      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          ch_nxt    = '0;
          state_nxt = ST_MULIN;
        end
      end
      ST_MULIN: begin
        cmd.op    = OP_MUL_IN;
        state_nxt = ST_SAVEIN;
      end
      ST_SAVEIN: begin
        cmd.op = OP_SAVE_IN;
        if (ch_last) begin
          state_nxt = ST_DIVSTART;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_MULIN;
        end
      end
      ST_DIVSTART: begin
        cmd.op    = OP_DIV_START;
        cnt_nxt   = '0;
        state_nxt = stat.div_go ? ST_DIVSTEP : ST_RELM1;
      end
      ST_DIVSTEP: begin
        cmd.op   = OP_DIV_STEP;
        cmd.last = (cnt_r == DIVCNT_W'(DIV_STEPS - 1));
        cnt_nxt  = cnt_r + 1'b1;
        if (cmd.last) state_nxt = ST_RELM1;
      end
      ST_RELM1: begin
        cmd.op    = OP_REL_M1;
        state_nxt = ST_RELM2;
      end
      ST_RELM2: begin
        cmd.op    = OP_REL_M2;
        state_nxt = ST_RELEND;
      end
      ST_RELEND: begin
        cmd.op    = OP_REL_END;
        ch_nxt    = '0;
        state_nxt = ST_SCMUL;
      end
      ST_SCMUL: begin
        cmd.op    = OP_SC_MUL;
        state_nxt = ST_SCSAVE;
      end
      ST_SCSAVE: begin
        cmd.op    = OP_SC_SAVE;
        state_nxt = ST_GMUL;
      end
      ST_GMUL: begin
        cmd.op    = OP_G_MUL;
        state_nxt = ST_GSAVE;
      end
      ST_GSAVE: begin
        cmd.op = OP_G_SAVE;
        if (ch_last) begin
          state_nxt = ST_FINISH;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_SCMUL;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.op        = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/spl_datapath.sv =====
// Datapath of the stereo peak limiter: configuration registers, shared
// multiplier, serial divider, envelope, meters and result registers.
// Depends on spl_pkg.
`timescale 1ns / 1ps
module spl_datapath import spl_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [SAMPLE_W-1:0]  left_in,
  input  logic signed [SAMPLE_W-1:0]  right_in,
  input  logic                        clear_meters,
  input  cmd_t                        cmd,
  output stat_t                       stat,
  output logic signed [SAMPLE_W-1:0]  left_out,
  output logic signed [SAMPLE_W-1:0]  right_out,
  output logic [SAMPLE_W-1:0]         gain_applied,
  output logic [WIDE_W-1:0]           input_peak,
  output logic [SAMPLE_W-1:0]         output_peak,
  output logic [COUNT_W-1:0]          clip_count,
  output logic [SAMPLE_W-1:0]         lowest_gain
);

  logic [GAIN_W-1:0]   in_gain_r;
  logic [SAMPLE_W-1:0] thr_r, ceil_r;
  logic [COEF_W-1:0]   coef_r;
  logic                sc_on_r, meters_on_r;
  logic [SLOPE_W-1:0]  slope_r;

  logic [SAMPLE_W-1:0] abs_r [CHANNELS];
  logic                neg_r [CHANNELS];
  logic [WIDE_W-1:0]   mag_r [CHANNELS];
  logic [SAMPLE_W-1:0] y_r   [CHANNELS];
  logic [WIDE_W-1:0]   peak_r, m2_r;
  logic [REM_W-1:0]    rem_r, dsh_r;
  logic [ENV_W-1:0]    quo_r, target_r, env_r;
  logic [PROD_W-1:0]   prod_r;
  logic [REM_W-1:0]    acc_r;

  logic [WIDE_W-1:0]   ipk_r, ipk_nxt;
  logic [SAMPLE_W-1:0] opk_r, low_r;
  logic [COUNT_W-1:0]  clip_r;

  logic signed [SAMPLE_W-1:0] smp [CHANNELS];
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [SAMPLE_W-1:0] gain, pos_lim, neg_lim, lim, y_new, low_nxt;
  logic [WIDE_W:0]     in_scaled;
  logic [WIDE_W-1:0]   in_mag;
  logic                div_ge;
  logic [REM_W-1:0]    rem_nxt;
  logic [ENV_W-1:0]    quo_nxt;
  logic [REM_W-1:0]    rel_sum;
  logic [WIDE_W+1:0]   sc_sum;
  logic [WIDE_W:0]     y_wide;
  logic                clip_hit;

  assign smp[0] = left_in;
  assign smp[1] = right_in;

  assign gain    = (env_r > ENV_W'(UNITY)) ? UNITY : env_r[SAMPLE_W-1:0];
  assign pos_lim = (ceil_r < UNITY_M1) ? ceil_r : UNITY_M1;
  assign neg_lim = (ceil_r < UNITY) ? ceil_r : UNITY;
  assign low_nxt = (gain < low_r) ? gain : low_r;

  assign stat.div_go = (peak_r > WIDE_W'(thr_r)) &&
                       ((WIDE_W + 2)'(ceil_r) < {peak_r, 2'b00});

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_IN: begin
        mul_a = MUL_A_W'(abs_r[cmd.ch]);
        mul_b = MUL_B_W'(in_gain_r);
      end
      OP_REL_M1: begin
        mul_a = MUL_A_W'(coef_r);
        mul_b = env_r;
      end
      OP_REL_M2: begin
        mul_a = MUL_A_W'(25'h1000000 - {1'b0, coef_r});
        mul_b = target_r;
      end
      OP_SC_MUL: begin
        mul_a = mag_r[cmd.ch] - KNEE;
        mul_b = MUL_B_W'(slope_r);
      end
      OP_G_MUL: begin
        mul_a = m2_r;
        mul_b = MUL_B_W'(gain);
      end
      default: ;
    endcase
  end

  always_comb begin
    in_scaled = prod_r[WIDE_W+12:12];
    in_mag    = (in_scaled > (WIDE_W + 1)'(WIDE_MAX)) ? WIDE_MAX : in_scaled[WIDE_W-1:0];
    div_ge    = (rem_r >= dsh_r);
    rem_nxt   = div_ge ? (rem_r - dsh_r) : rem_r;
    quo_nxt   = {quo_r[ENV_W-2:0], div_ge};
    rel_sum   = acc_r + prod_r[REM_W-1:0] + REM_W'(UNITY);
    sc_sum    = (WIDE_W + 2)'(KNEE) + (WIDE_W + 2)'(prod_r[WIDE_W+16:16]);
    y_wide    = prod_r[WIDE_W+FRAC_W:FRAC_W];
    lim       = neg_r[cmd.ch] ? neg_lim : pos_lim;
    y_new     = (y_wide > (WIDE_W + 1)'(lim)) ? lim : y_wide[SAMPLE_W-1:0];
    clip_hit  = (COUNT_W'(y_new) * COUNT_W'(100)) >= (COUNT_W'(ceil_r) * COUNT_W'(99));
    ipk_nxt   = (mag_r[cmd.ch] > ipk_r) ? mag_r[cmd.ch] : ipk_r;
  end

  // configuration, envelope and meters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_gain_r   <= RST_INPUT_GAIN;
      thr_r       <= UNITY;
      ceil_r      <= UNITY;
      coef_r      <= RST_RELEASE;
      sc_on_r     <= 1'b0;
      slope_r     <= RST_SLOPE;
      meters_on_r <= 1'b1;
      env_r       <= '0;
      ipk_r       <= '0;
      opk_r       <= '0;
      clip_r      <= '0;
      low_r       <= UNITY;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_INPUT_GAIN: in_gain_r   <= cfg_data[GAIN_W-1:0];
          CFG_THRESHOLD:  thr_r       <= cfg_data[SAMPLE_W-1:0];
          CFG_CEILING:    ceil_r      <= cfg_data[SAMPLE_W-1:0];
          CFG_RELEASE:    coef_r      <= cfg_data[COEF_W-1:0];
          CFG_SC_ON:      sc_on_r     <= cfg_data[0];
          CFG_SC_SLOPE:   slope_r     <= cfg_data[SLOPE_W-1:0];
          CFG_METERS_ON:  meters_on_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          if (clear_meters) begin
            ipk_r  <= '0;
            opk_r  <= '0;
            clip_r <= '0;
            low_r  <= UNITY;
          end
        end
        OP_REL_END: begin
          env_r <= (target_r < env_r) ? target_r : rel_sum[ENV_W+23:24];
        end
        OP_G_SAVE: begin
          if (meters_on_r) begin
            ipk_r <= ipk_nxt;
            if (y_new > opk_r) opk_r <= y_new;
            if (clip_hit && clip_r != COUNT_MAX) clip_r <= clip_r + 1'b1;
          end
        end
        OP_FINISH: low_r <= low_nxt;
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (cmd.op)
      OP_LOAD: begin
        for (int c = 0; c < CHANNELS; c++) begin
          neg_r[c] <= smp[c][SAMPLE_W-1];
          abs_r[c] <= smp[c][SAMPLE_W-1] ? SAMPLE_W'(-smp[c]) : SAMPLE_W'(smp[c]);
        end
        peak_r <= '0;
      end
      OP_SAVE_IN: begin
        mag_r[cmd.ch] <= in_mag;
        if (in_mag > peak_r) peak_r <= in_mag;
      end
      OP_DIV_START: begin
        if (peak_r > WIDE_W'(thr_r)) begin
          target_r <= stat.div_go ? target_r : ENV_MAX;
        end else begin
          target_r <= ENV_W'(UNITY);
        end
        rem_r <= REM_W'(ceil_r) << FRAC_W;
        dsh_r <= REM_W'(peak_r) << (ENV_W - 1);
        quo_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= rem_nxt;
        dsh_r <= dsh_r >> 1;
        quo_r <= quo_nxt;
        if (cmd.last) target_r <= quo_nxt;
      end
      OP_REL_M2: acc_r <= prod_r[REM_W-1:0];
      OP_SC_SAVE: begin
        if (sc_on_r && mag_r[cmd.ch] > KNEE) begin
          m2_r <= (sc_sum > (WIDE_W + 2)'(WIDE_MAX)) ? WIDE_MAX : sc_sum[WIDE_W-1:0];
        end else begin
          m2_r <= mag_r[cmd.ch];
        end
      end
      OP_G_SAVE: y_r[cmd.ch] <= y_new;
      OP_FINISH: begin
        left_out     <= neg_r[0] ? -$signed(y_r[0]) : $signed(y_r[0]);
        right_out    <= neg_r[1] ? -$signed(y_r[1]) : $signed(y_r[1]);
        gain_applied <= gain;
        input_peak   <= ipk_r;
        output_peak  <= opk_r;
        clip_count   <= clip_r;
        lowest_gain  <= low_nxt;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/stereo_peak_limiter.sv =====
// Top level of the stereo peak limiter: ties the controller to the datapath.
// Depends on spl_pkg, spl_ctrl and spl_datapath.
`timescale 1ns / 1ps
// A frame skips the divider when its peak stays at or below the threshold,
// or when the target saturates because the ceiling is at least four times
// the peak. Otherwise the divider runs: the target gain comes from a
// restoring divider that resolves a 25-bit quotient one bit per cycle. Every
// product of the frame (input gain, release filter, soft clip, output gain)
// goes through a single shared multiplier whose product is registered. The
// result sits in an output register, so the next frame is taken while a
// finished beat waits. A frame that finishes before that beat is taken holds
// until the slot frees. Meter values in each result reflect that frame's
// update. Write configuration only while idle.
module stereo_peak_limiter import spl_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_left_in,
  input  logic signed [SAMPLE_W-1:0] in_right_in,
  input  logic                       in_clear_meters,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out,
  output logic [SAMPLE_W-1:0]        out_gain_applied,
  output logic [WIDE_W-1:0]          out_input_peak,
  output logic [SAMPLE_W-1:0]        out_output_peak,
  output logic [COUNT_W-1:0]         out_clip_count,
  output logic [SAMPLE_W-1:0]        out_lowest_gain
);

  cmd_t  cmd;
  stat_t stat;

  // sequence the frame
  spl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // do the arithmetic and hold the meters
  spl_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_in      (in_left_in),
    .right_in     (in_right_in),
    .clear_meters (in_clear_meters),
    .cmd          (cmd),
    .stat         (stat),
    .left_out     (out_left_out),
    .right_out    (out_right_out),
    .gain_applied (out_gain_applied),
    .input_peak   (out_input_peak),
    .output_peak  (out_output_peak),
    .clip_count   (out_clip_count),
    .lowest_gain  (out_lowest_gain)
  );

endmodule

// ===== rtl/spl_checker.sv =====
// Port-level checks of the stereo peak limiter, bound to the top level.
// Depends on spl_pkg and stereo_peak_limiter.
`timescale 1ns / 1ps
module spl_checker import spl_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_gain_applied,
  input logic [SAMPLE_W-1:0] out_output_peak,
  input logic [SAMPLE_W-1:0] out_lowest_gain
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain_applied <= UNITY)
    else $error("gain above unity");

  a_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lowest_gain <= out_gain_applied)
    else $error("lowest gain above applied gain");

  a_opk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_output_peak <= UNITY)
    else $error("output peak above full scale");

endmodule

bind stereo_peak_limiter spl_checker u_spl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_gain_applied (out_gain_applied),
  .out_output_peak  (out_output_peak),
  .out_lowest_gain  (out_lowest_gain)
);

// ===== tb/tb_stereo_peak_limiter.sv =====
// Self-checking testbench for the stereo peak limiter: random and directed
// frames, an in-bench limiter predictor and a scoreboard class.
// Depends on spl_pkg and the stereo_peak_limiter RTL.
`timescale 1ns / 1ps
module tb_stereo_peak_limiter;
  import spl_pkg::*;

  typedef struct {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] gain;
    logic [WIDE_W-1:0]   in_peak;
    logic [SAMPLE_W-1:0] out_peak;
    logic [COUNT_W-1:0]  clips;
    logic [SAMPLE_W-1:0] low_gain;
  } frame_out_t;

  // Limiter predictor: holds its own copy of registers and state, and queues
  // the expected result beat for every accepted frame.
  class limiter_scoreboard;
    longint unsigned in_gain, thresh, ceil, rel_coef, sc_on, sc_slope, met_on;
    longint unsigned env, in_pk, out_pk, low_g;
    longint unsigned clips;
    frame_out_t pending[$];
    int errors;

    function void reset_state();
      in_gain = 4096; thresh = UNITY; ceil = UNITY; rel_coef = RST_RELEASE;
      sc_on = 0; sc_slope = RST_SLOPE; met_on = 1; env = 0;
      in_pk = 0; out_pk = 0; clips = 0; low_g = UNITY;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, longint unsigned v);
      case (idx)
        CFG_INPUT_GAIN: in_gain = v & 16'hFFFF;
        CFG_THRESHOLD:  thresh = v & 24'hFFFFFF;
        CFG_CEILING:    ceil = v & 24'hFFFFFF;
        CFG_RELEASE:    rel_coef = v & 24'hFFFFFF;
        CFG_SC_ON:      sc_on = v & 1;
        CFG_SC_SLOPE:   sc_slope = v & 17'h1FFFF;
        CFG_METERS_ON:  met_on = v & 1;
        default: ;
      endcase
    endfunction

    function void note_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, bit clr);
      longint unsigned mag[2], y[2], pk, tgt, g, m, lim;
      bit neg[2];
      logic [SAMPLE_W-1:0] smp[2];
      frame_out_t f;
      smp[0] = l; smp[1] = r;
      if (clr) begin
        in_pk = 0; out_pk = 0; clips = 0; low_g = UNITY;
      end
      pk = 0;
      for (int c = 0; c < 2; c++) begin
        neg[c] = smp[c][SAMPLE_W-1];
        m = neg[c] ? (64'd1 << SAMPLE_W) - smp[c] : smp[c];
        m = (m * in_gain) >> 12;
        if (m > WIDE_MAX) m = WIDE_MAX;
        mag[c] = m;
        if (m > pk) pk = m;
      end
      if (pk > thresh) begin
        tgt = (ceil << FRAC_W) / pk;
        if (tgt > ENV_MAX) tgt = ENV_MAX;
      end else begin
        tgt = UNITY;
      end
      if (tgt < env) env = tgt;
      else env = (rel_coef * env + ((64'd1 << 24) - rel_coef) * tgt + (64'd1 << 23)) >> 24;
      g = env < UNITY ? env : UNITY;
      for (int c = 0; c < 2; c++) begin
        m = mag[c];
        if (sc_on != 0 && m > KNEE) begin
          m = KNEE + (((m - KNEE) * sc_slope) >> 16);
          if (m > WIDE_MAX) m = WIDE_MAX;
        end
        y[c] = (m >> FRAC_W) * g + (((m & (UNITY - 1)) * g) >> FRAC_W);
        lim = neg[c] ? (ceil < UNITY ? ceil : UNITY) : (ceil < UNITY_M1 ? ceil : UNITY_M1);
        if (y[c] > lim) y[c] = lim;
        if (met_on != 0) begin
          if (mag[c] > in_pk) in_pk = mag[c];
          if (y[c] > out_pk) out_pk = y[c];
          if (y[c] * 100 >= ceil * 99 && clips < COUNT_MAX) clips++;
        end
      end
      if (g < low_g) low_g = g;
      f.left  = neg[0] ? -y[0] : y[0];
      f.right = neg[1] ? -y[1] : y[1];
      f.gain = g; f.in_peak = in_pk; f.out_peak = out_pk;
      f.clips = clips; f.low_gain = low_g;
      pending.push_back(f);
    endfunction

    function void compare(string nm, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $display("%0t mismatch %s expected %0h actual %0h", $time, nm, e, a);
        errors++;
      end
    endfunction

    function void check_beat(frame_out_t a);
      frame_out_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result beat, actual left %0h", $time, a.left);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare("left_out", e.left, a.left);
      compare("right_out", e.right, a.right);
      compare("gain_applied", e.gain, a.gain);
      compare("input_peak", e.in_peak, a.in_peak);
      compare("output_peak", e.out_peak, a.out_peak);
      compare("clip_count", e.clips, a.clips);
      compare("lowest_gain", e.low_gain, a.low_gain);
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, in_clear_meters;
  logic signed [SAMPLE_W-1:0] in_left_in, in_right_in;
  logic out_valid, out_ready;
  logic signed [SAMPLE_W-1:0] out_left_out, out_right_out;
  logic [SAMPLE_W-1:0] out_gain_applied, out_output_peak, out_lowest_gain;
  logic [WIDE_W-1:0] out_input_peak;
  logic [COUNT_W-1:0] out_clip_count;

  limiter_scoreboard sb;
  bit quiet;          // no idling in the closing stretch
  longint cycles;

  stereo_peak_limiter i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: the limit allows several times the worst-case frame time plus
  // the idle and stall gaps on both sides for every frame.
  localparam longint CYCLE_LIMIT = 400000;
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("stereo_peak_limiter regression: fail");
        $finish;
      end
    end
  end

  // Result side: sample at the edge, stall in random bursts.
  initial begin
    int stall;
    frame_out_t a;
    out_ready = 0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        a.left = out_left_out; a.right = out_right_out; a.gain = out_gain_applied;
        a.in_peak = out_input_peak; a.out_peak = out_output_peak;
        a.clips = out_clip_count; a.low_gain = out_lowest_gain;
        sb.check_beat(a);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Drop the input, wait until no frame is in flight, then write one register.
  task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  // Drive one beat and hold it until accepted; optional idle burst before.
  task automatic send_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, bit clr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1; in_left_in <= l; in_right_in <= r; in_clear_meters <= clr;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(l, r, clr);
  endtask

  // Drop the input, wait for the scoreboard to empty, then let the block settle.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return $urandom_range(0, 255);
      3: return -$urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_frames(int n);
    for (int i = 0; i < n; i++)
      send_frame(rand_sample(), rand_sample(), $urandom_range(0, 40) == 0);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    quiet = 0;
    rst_n = 0; cfg_wr_en = 0; cfg_index = CFG_INPUT_GAIN; cfg_data = 0;
    in_valid = 0; in_left_in = 0; in_right_in = 0; in_clear_meters = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes from reset, the gain rising out of zero envelope.
    send_frame(24'h000000, 24'h000000, 0);
    send_frame(24'h7FFFFF, 24'h800000, 0);
    send_frame(24'h800000, 24'h7FFFFF, 0);
    send_frame(24'hFFFFFF, 24'h000001, 1);
    drain();
    // Heavy drive, low threshold, soft clip with slope above unity.
    write_cfg(CFG_INPUT_GAIN, 16'hFFFF);
    write_cfg(CFG_THRESHOLD, 24'd1000);
    write_cfg(CFG_CEILING, 24'd4194304);
    write_cfg(CFG_RELEASE, 24'd0);
    write_cfg(CFG_SC_ON, 1);
    write_cfg(CFG_SC_SLOPE, 17'h1FFFF);
    write_cfg(CFG_METERS_ON, 1);
    send_frame(24'h7FFFFF, 24'h800000, 0);
    send_frame(24'h000001, 24'hFFFFFF, 0);
    send_frame(24'h600000, 24'hA00000, 0);
    send_frame(24'h000000, 24'h000000, 0);
    drain();
    // Zero ceiling counts every sample; zero threshold; meters off.
    write_cfg(CFG_CEILING, 24'd0);
    write_cfg(CFG_THRESHOLD, 24'd0);
    write_cfg(CFG_RELEASE, 24'hFFFFFF);
    write_cfg(CFG_METERS_ON, 0);
    send_frame(24'h000000, 24'h000001, 0);
    send_frame(24'h400000, 24'hC00000, 0);
    write_cfg(CFG_METERS_ON, 1);
    send_frame(24'h400000, 24'hC00000, 0);
    send_frame(24'h000000, 24'h000000, 1);
    drain();
    // Threshold and ceiling above full scale, zero input gain, zero slope.
    write_cfg(CFG_THRESHOLD, 24'hFFFFFF);
    write_cfg(CFG_CEILING, 24'hFFFFFF);
    write_cfg(CFG_SC_SLOPE, 17'd0);
    send_frame(24'h7FFFFF, 24'h800000, 0);
    write_cfg(CFG_INPUT_GAIN, 16'd0);
    drain();
    send_frame(24'h7FFFFF, 24'h800000, 0);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_INPUT_GAIN, (ph % 3 == 0) ? 16'd4096 : $urandom_range(0, 65535));
      write_cfg(CFG_THRESHOLD, $urandom_range(0, 8388608));
      write_cfg(CFG_CEILING, (ph == 2) ? 24'd8388608 : $urandom_range(0, 8388608));
      write_cfg(CFG_RELEASE, (ph == 5) ? 24'd0 : $urandom_range(16000000, 16777215));
      write_cfg(CFG_SC_ON, ph[0]);
      write_cfg(CFG_SC_SLOPE, $urandom_range(0, 65536));
      write_cfg(CFG_METERS_ON, ph != 6);
      random_frames(110);
      drain();   // sender holds off until every result is back
    end
    quiet = 1;
    random_frames(120);
    drain();

    if (sb.errors == 0)
      $display("stereo_peak_limiter regression: pass");
    else
      $display("stereo_peak_limiter regression: fail");
    $finish;
  end
endmodule
